@@ design/nspw_pkg.sv @@
// Package: widths, coefficient tables and CORDIC angle table for the phase wrapper.
`default_nettype none
package nspw_pkg;
  localparam int unsigned MaxFringesDef = 8;
  localparam int unsigned PhaseBitsDef  = 16;
  localparam int unsigned MinFringes    = 3;
  localparam int unsigned SampleW       = 8;
  localparam int unsigned CoefW         = 16;
  localparam int unsigned SumW          = 28;
  localparam int unsigned CordW         = 40;
  localparam int unsigned CountW        = 4;
  localparam int unsigned OutW          = 16;
  localparam logic [CountW-1:0] FringeReset = 4'd5;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [CordW-1:0] cord_t;

  typedef enum logic [0:0] {
    REG_FRINGE_COUNT = 1'b0
  } reg_idx_t;

  function automatic logic signed [CoefW-1:0] sin_coef(input logic [2:0] n3, input logic [2:0] k);
    logic signed [CoefW-1:0] v;
    v = '0;
    case (n3)
      3'd0: case (k) 3'd1: v = 16'sd28378; 3'd2: v = -16'sd28378; default: v = '0; endcase
      3'd1: case (k) 3'd1: v = 16'sd32767; 3'd3: v = -16'sd32768; default: v = '0; endcase
      3'd2: case (k)
        3'd1: v = 16'sd31164; 3'd2: v = 16'sd19261; 3'd3: v = -16'sd19261;
        3'd4: v = -16'sd31164; default: v = '0;
      endcase
      3'd3: case (k)
        3'd1: v = 16'sd28378; 3'd2: v = 16'sd28378; 3'd4: v = -16'sd28378;
        3'd5: v = -16'sd28378; default: v = '0;
      endcase
      3'd4: case (k)
        3'd1: v = 16'sd25619; 3'd2: v = 16'sd31946; 3'd3: v = 16'sd14218;
        3'd4: v = -16'sd14218; 3'd5: v = -16'sd31946; 3'd6: v = -16'sd25619;
        default: v = '0;
      endcase
      3'd5: case (k)
        3'd1: v = 16'sd23170; 3'd2: v = 16'sd32767; 3'd3: v = 16'sd23170;
        3'd5: v = -16'sd23170; 3'd6: v = -16'sd32768; 3'd7: v = -16'sd23170;
        default: v = '0;
      endcase
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CoefW-1:0] cos_coef(input logic [2:0] n3, input logic [2:0] k);
    logic signed [CoefW-1:0] v;
    v = '0;
    case (n3)
      3'd0: case (k)
        3'd0: v = 16'sd32767; 3'd1: v = -16'sd16384; 3'd2: v = -16'sd16384; default: v = '0;
      endcase
      3'd1: case (k) 3'd0: v = 16'sd32767; 3'd2: v = -16'sd32768; default: v = '0; endcase
      3'd2: case (k)
        3'd0: v = 16'sd32767; 3'd1: v = 16'sd10126; 3'd2: v = -16'sd26510;
        3'd3: v = -16'sd26510; 3'd4: v = 16'sd10126; default: v = '0;
      endcase
      3'd3: case (k)
        3'd0: v = 16'sd32767; 3'd1: v = 16'sd16384; 3'd2: v = -16'sd16384;
        3'd3: v = -16'sd32768; 3'd4: v = -16'sd16384; 3'd5: v = 16'sd16384;
        default: v = '0;
      endcase
      3'd4: case (k)
        3'd0: v = 16'sd32767; 3'd1: v = 16'sd20431; 3'd2: v = -16'sd7292;
        3'd3: v = -16'sd29523; 3'd4: v = -16'sd29523; 3'd5: v = -16'sd7292;
        3'd6: v = 16'sd20431; default: v = '0;
      endcase
      3'd5: case (k)
        3'd0: v = 16'sd32767; 3'd1: v = 16'sd23170; 3'd3: v = -16'sd23170;
        3'd4: v = -16'sd32768; 3'd5: v = -16'sd23170; 3'd7: v = 16'sd23170;
        default: v = '0;
      endcase
      default: v = '0;
    endcase
    return v;
  endfunction

  // atan(2^-i) with pi = 2^31
  function automatic logic [31:0] atan_pi31(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;  5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;  5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;  5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;  5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

@@ design/nspw_sums.sv @@
// Two-stage multiply-accumulate forming the sine and cosine sums of one pixel.
`default_nettype none
module nspw_sums import nspw_pkg::*; #(
  parameter int unsigned MAX_FRINGES = MaxFringesDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_vld,
  input  wire logic [2:0]         n3,
  input  wire sample_t            samples [MAX_FRINGES],
  output logic                    vld_o,
  output sum_t                    s_o,
  output sum_t                    c_o
);
  localparam int unsigned NP = MAX_FRINGES;
  logic signed [SumW-1:0] ps_r [NP];
  logic signed [SumW-1:0] pc_r [NP];
  logic vld1_r, vld2_r;
  sum_t s_r, c_r;
  sum_t s_nxt, c_nxt;

  // stage 1: products, lanes past N get zero coefficients
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NP; k++) begin
        ps_r[k] <= sum_t'($signed({1'b0, samples[k]})) * sum_t'(sin_coef(n3, 3'(k)));
        pc_r[k] <= sum_t'($signed({1'b0, samples[k]})) * sum_t'(cos_coef(n3, 3'(k)));
      end
    end
  end

  always_comb begin
    s_nxt = '0;
    c_nxt = '0;
    for (int k = 0; k < NP; k++) begin
      s_nxt = s_nxt + ps_r[k];
      c_nxt = c_nxt + pc_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o = vld2_r;
  assign s_o   = s_r;
  assign c_o   = c_r;
endmodule
`default_nettype wire

@@ design/nspw_cordic.sv @@
// Pipelined vectoring CORDIC, one rotation per stage, giving the negated wrapped phase.
`default_nettype none
module nspw_cordic import nspw_pkg::*; #(
  parameter int unsigned PHASE_BITS = PhaseBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              vld_i,
  input  wire sum_t              s_i,
  input  wire sum_t              c_i,
  output logic                   vld_o,
  output logic [OutW-1:0]        phase_o
);
  localparam int unsigned NS = PHASE_BITS;
  localparam int unsigned SH = 32 - PHASE_BITS;

  cord_t x_r [NS+1];
  cord_t y_r [NS+1];
  logic [PHASE_BITS-1:0] z_r [NS+1];
  logic zero_r [NS+1];
  logic vld_r [NS+1];
  logic [OutW-1:0] ph_r;
  logic ph_vld_r;

  cord_t x0, y0;
  logic [PHASE_BITS-1:0] zneg;
  logic [OutW-1:0] ph_nxt;

  // prescale by 256 and fold the left half plane
  always_comb begin
    x0 = cord_t'(c_i) <<< 8;
    y0 = cord_t'(s_i) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (x0 < 0) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        z_r[0] <= PHASE_BITS'(1) << (PHASE_BITS - 1);
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        z_r[0] <= '0;
      end
      zero_r[0] <= (s_i == '0) && (c_i == '0);
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [32:0] ROUNDED = (33'(atan_pi31(5'(i))) + (33'd1 << (SH - 1))) >> SH;
    localparam logic [PHASE_BITS-1:0] AI = PHASE_BITS'(ROUNDED);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_r[i][CordW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AI;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AI;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) vld_r[i] <= 1'b0;
      ph_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= vld_i;
      for (int i = 0; i < NS; i++) vld_r[i+1] <= vld_r[i];
      ph_vld_r <= vld_r[NS];
    end
  end

  always_comb begin
    zneg = -z_r[NS];
    if (PHASE_BITS > OutW) begin
      ph_nxt = OutW'((33'(zneg) + (33'd1 << (PHASE_BITS - OutW - 1))) >> (PHASE_BITS - OutW));
    end else begin
      ph_nxt = OutW'(33'(zneg) << (OutW - PHASE_BITS));
    end
    if (zero_r[NS]) ph_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) ph_r <= ph_nxt;
  end

  assign vld_o   = ph_vld_r;
  assign phase_o = ph_r;
endmodule
`default_nettype wire

@@ design/n_step_phase_wrapper.sv @@
// Top level: N-step phase-shifting wrapped phase, pipelined one pixel per clock while out_ready allows.
// Usage:
//   Input channel in_valid/in_ready carries one pixel as eight 8-bit samples;
//   only the first fringe_count (3..8, clamped) are used.
//   Output channel out_valid/out_ready carries out_wrapped_phase, -atan2(S,C)
//   with 32768 = pi; an all-zero sum vector gives 0.
//   Pipeline stages: two MAC stages, one fold stage, one stage per CORDIC
//   rotation, one output stage.
//   One word per clock unless out_ready stalls. The whole pipeline
//   advances together; when the receiver stalls with a word waiting, the
//   pipeline holds and in_ready drops, so nothing is lost or repeated. Empty
//   slots travel with the pipeline; in_ready stays high while the last stage
//   is empty. Reset (rst_n low, synchronous) empties the pipeline and sets
//   fringe_count to 5. Configuration via APB at address 0, write when idle.
`default_nettype none
module n_step_phase_wrapper import nspw_pkg::*; #(
  parameter int unsigned MAX_FRINGES = MaxFringesDef,
  parameter int unsigned PHASE_BITS  = PhaseBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_sample_0,
  input  wire logic [7:0]        in_sample_1,
  input  wire logic [7:0]        in_sample_2,
  input  wire logic [7:0]        in_sample_3,
  input  wire logic [7:0]        in_sample_4,
  input  wire logic [7:0]        in_sample_5,
  input  wire logic [7:0]        in_sample_6,
  input  wire logic [7:0]        in_sample_7,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     out_wrapped_phase,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [CountW-1:0] fringe_r;
  logic [3:0] n_eff;
  logic [2:0] n3;
  logic adv;
  sample_t all_s [8];
  sample_t samples [MAX_FRINGES];
  logic sum_vld, out_vld;
  sum_t s_sum, c_sum;
  logic [OutW-1:0] phase;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr[2] == REG_FRINGE_COUNT) && (cfg_paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fringe_r <= FringeReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      fringe_r <= cfg_pwdata[CountW-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? {{(32-CountW){1'b0}}, fringe_r} : '0;

  always_comb begin
    n_eff = fringe_r;
    if (n_eff < 4'(MinFringes)) n_eff = 4'(MinFringes);
    if (n_eff > 4'(MAX_FRINGES)) n_eff = 4'(MAX_FRINGES);
    n3 = 3'(n_eff - 4'(MinFringes));
  end

  assign all_s = '{in_sample_0, in_sample_1, in_sample_2, in_sample_3,
                   in_sample_4, in_sample_5, in_sample_6, in_sample_7};
  always_comb begin
    for (int k = 0; k < MAX_FRINGES; k++) samples[k] = all_s[k];
  end

  // hold everything while a finished word waits
  assign adv      = !out_vld || out_ready;
  assign in_ready = adv;

  nspw_sums #(.MAX_FRINGES(MAX_FRINGES)) u_sums (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid),
    .n3(n3), .samples(samples), .vld_o(sum_vld), .s_o(s_sum), .c_o(c_sum)
  );

  nspw_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(sum_vld),
    .s_i(s_sum), .c_i(c_sum), .vld_o(out_vld), .phase_o(phase)
  );

  assign out_valid         = out_vld;
  assign out_wrapped_phase = $signed(phase);
endmodule
`default_nettype wire
